### sv/psc_pkg.sv
// psc_pkg: shared types and constants of the PID speed controller.
// No dependencies.
`default_nettype none
package psc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned Q_W        = 16;
  localparam int unsigned MUL_A_W    = 32;
  localparam int unsigned MUL_B_W    = 25;
  localparam int unsigned CHUNK_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_UPPER  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LOWER  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_MODE = 3'd7;

  localparam logic [1:0] DMODE_PLAIN = 2'd0;
  localparam logic [1:0] DMODE_LPF   = 2'd1;
  localparam logic [1:0] DMODE_MEAS  = 2'd2;

  localparam logic [15:0] LPF_NEW = 16'd10158;
  localparam logic [15:0] LPF_OLD = 16'd22610;

  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
    logic hi;
  } mac_cmd_t;

endpackage
`default_nettype wire

### sv/psc_in_if.sv
// psc_in_if: sample channel (target and measured speed).
// No dependencies.
`default_nettype none
interface psc_in_if #(parameter int unsigned SPEED_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] target_speed;
  logic signed [SPEED_WIDTH-1:0] measured_speed;
  modport source (output valid, target_speed, measured_speed, input ready);
  modport sink (input valid, target_speed, measured_speed, output ready);
endinterface
`default_nettype wire

### sv/psc_out_if.sv
// psc_out_if: result channel (drive value and saturation flag).
// No dependencies.
`default_nettype none
interface psc_out_if #(parameter int unsigned SPEED_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] drive;
  logic                          saturated;
  modport source (output valid, drive, saturated, input ready);
  modport sink (input valid, drive, saturated, output ready);
endinterface
`default_nettype wire

### sv/psc_cfg_if.sv
// psc_cfg_if: register write channel.
// Depends on psc_pkg.
`default_nettype none
interface psc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [psc_pkg::CFG_IDX_W-1:0]     index;
  logic [psc_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/psc_div.sv
// psc_div: restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module psc_div #(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 21
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             active_r, active_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = CNT_W'(NUM_W);
      quo_nxt    = num;
      rem_nxt    = '0;
      den_nxt    = den;
    end else if (active_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

### sv/psc_mac.sv
// psc_mac: shared signed multiplier with registered product and accumulator.
// Depends on psc_pkg.
`default_nettype none
module psc_mac #(
  parameter int unsigned ACC_W = 80
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire psc_pkg::mac_cmd_t                   cmd,
  input  wire logic signed [psc_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [psc_pkg::MUL_B_W-1:0]  b,
  output logic signed [ACC_W-1:0]                  acc
);
  localparam int unsigned PROD_W = psc_pkg::MUL_A_W + psc_pkg::MUL_B_W;

  psc_pkg::mac_cmd_t        cmd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;

  always_comb begin
    term = ACC_W'(prod_r);
    if (cmd_r.hi) begin
      term = term <<< psc_pkg::CHUNK_W;
    end
    base    = cmd_r.clr ? '0 : acc_r;
    acc_nxt = acc_r;
    if (cmd_r.en) begin
      acc_nxt = cmd_r.neg ? base - term : base + term;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0;
    end else begin
      cmd_r <= cmd;
    end
    prod_r <= a * b;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;
endmodule
`default_nettype wire

### sv/pid_speed_controller_antiwindup.sv
// pid_speed_controller_antiwindup: PID speed loop with integral separation and anti-windup.
// Depends on psc_pkg, psc_in_if, psc_out_if, psc_cfg_if, psc_div, psc_mac.
//
//  port    dir  handshake     beat
//  in_ch   in   valid/ready   target_speed, measured_speed
//  out_ch  out  valid/ready   drive, saturated
//  cfg_ch  in   valid/ready   index, data (always ready)
//
// One sample at a time. Each sample takes two normalization divides, one more divide
// when the separation weight needs it, three coefficient divides in
// derivative-on-measurement mode unless kd + 10*kp is zero, and the shared multiplier
// sequence; the serial divider works on D = max(SPEED_WIDTH+13, 37) bits (37 at 16 bits).
// Reset is synchronous; state, configuration, integrator and history registers return to their defaults.
// A finished result waits in the output register while the next sample is taken.
`default_nettype none
module pid_speed_controller_antiwindup #(
  parameter int unsigned SPEED_WIDTH    = 16,
  parameter int unsigned INTEGRAL_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  psc_in_if.sink     in_ch,
  psc_out_if.source  out_ch,
  psc_cfg_if.sink    cfg_ch
);
  localparam int unsigned SW    = SPEED_WIDTH;
  localparam int unsigned IW    = INTEGRAL_WIDTH;
  localparam int unsigned DV_W  = (SW + 13 > 37) ? SW + 13 : 37;
  localparam int unsigned DD_W  = 21;
  localparam int unsigned ACC_W = (IW + 33 > 58) ? IW + 33 : 58;
  localparam int unsigned ITW   = IW + 2;
  localparam int unsigned SSW   = IW + 4;
  localparam int unsigned WW    = ((SW > 17) ? SW : 17) + 6;
  localparam int unsigned MAGX_W = 2 * psc_pkg::CHUNK_W;
  localparam int unsigned A_W   = psc_pkg::MUL_A_W;
  localparam int unsigned B_W   = psc_pkg::MUL_B_W;

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_NT_GO = 6'd1;
  localparam logic [5:0] S_NT_WT = 6'd2;
  localparam logic [5:0] S_NM_GO = 6'd3;
  localparam logic [5:0] S_NM_WT = 6'd4;
  localparam logic [5:0] S_ERR   = 6'd5;
  localparam logic [5:0] S_W_GO  = 6'd6;
  localparam logic [5:0] S_W_WT  = 6'd7;
  localparam logic [5:0] S_P     = 6'd8;
  localparam logic [5:0] S_K     = 6'd9;
  localparam logic [5:0] S_PR    = 6'd10;
  localparam logic [5:0] S_KR    = 6'd11;
  localparam logic [5:0] S_I0    = 6'd12;
  localparam logic [5:0] S_I1    = 6'd13;
  localparam logic [5:0] S_IW    = 6'd14;
  localparam logic [5:0] S_IR    = 6'd15;
  localparam logic [5:0] S_D0    = 6'd16;
  localparam logic [5:0] S_DW    = 6'd17;
  localparam logic [5:0] S_DR    = 6'd18;
  localparam logic [5:0] S_F0    = 6'd19;
  localparam logic [5:0] S_F1    = 6'd20;
  localparam logic [5:0] S_FW    = 6'd21;
  localparam logic [5:0] S_FR    = 6'd22;
  localparam logic [5:0] S_C_GO  = 6'd23;
  localparam logic [5:0] S_C_WT  = 6'd24;
  localparam logic [5:0] S_M0    = 6'd25;
  localparam logic [5:0] S_M1    = 6'd26;
  localparam logic [5:0] S_M2    = 6'd27;
  localparam logic [5:0] S_MW    = 6'd28;
  localparam logic [5:0] S_MR    = 6'd29;
  localparam logic [5:0] S_SUM   = 6'd30;
  localparam logic [5:0] S_OM    = 6'd31;
  localparam logic [5:0] S_OW    = 6'd32;
  localparam logic [5:0] S_OR    = 6'd33;

  localparam logic signed [ACC_W-1:0] Q_MAXV = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Q_MINV = -ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] DLIM   = ACC_W'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [SSW-1:0]   S_ONE  = SSW'(4096);

  function automatic logic signed [ACC_W-1:0] rnd_sh(input logic signed [ACC_W-1:0] x,
                                                    input int unsigned n);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] half;
    logic [ACC_W-1:0] r;
    mag  = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    half = ACC_W'(1) << (n - 1);
    r    = (mag + half) >> n;
    return x[ACC_W-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
    if (x > Q_MAXV) begin
      return 16'sh7fff;
    end else if (x < Q_MINV) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  // configuration
  logic [14:0]        max_speed_r;
  logic signed [15:0] min_speed_r;
  logic [15:0]        prop_gain_r, integ_gain_r, deriv_gain_r, sep_upper_r, sep_lower_r;
  logic [1:0]         deriv_mode_r;

  // control and state
  logic [5:0]            state_r, state_nxt;
  logic [1:0]            cidx_r, cidx_nxt;
  logic signed [SW-1:0]  tc_r, meas_r;
  logic signed [15:0]    setn_r, realn_r, err_r, last_err_r, fl_r, dl_r, ml_r, x_r;
  logic [16:0]           w_r;
  logic [30:0]           k_r;
  logic signed [19:0]    p_r, d_r;
  logic [19:0]           c1_r, c2_r, c3_r;
  logic signed [ITW-1:0] iterm_r;
  logic signed [IW-1:0]  integ_r;
  logic signed [13:0]    sc_r;
  logic                  sat_r;
  logic                  out_valid_r;
  logic signed [SW-1:0]  out_drive_r;
  logic                  out_sat_r;

  logic [15:0] smax, negdiv;
  assign smax   = (max_speed_r == 15'd0) ? 16'd1 : {1'b0, max_speed_r};
  assign negdiv = min_speed_r[15] ? 16'(-min_speed_r) : 16'd1;

  // input clamp
  logic signed [WW-1:0] tgt_x, smax_x, negd_x, tcl_x, meas_x;
  assign tgt_x  = WW'(in_ch.target_speed);
  assign smax_x = $signed({{(WW-16){1'b0}}, smax});
  assign negd_x = $signed({{(WW-16){1'b0}}, negdiv});
  always_comb begin
    tcl_x = tgt_x;
    if (tgt_x > smax_x) begin
      tcl_x = smax_x;
    end else if (tgt_x < -negd_x) begin
      tcl_x = -negd_x;
    end
  end

  // divider
  logic            div_start, div_done;
  logic [DV_W-1:0] div_num, div_quo;
  logic [DD_W-1:0] div_den;
  logic [SW-1:0]   nmag;
  logic            nneg;
  logic [19:0]     kp20, ks20, kd20, den_m;
  logic [DV_W-1:0] ncoef;
  logic [18:0]     abse;
  logic [15:0]     abs_err;

  assign kp20  = 20'(prop_gain_r);
  assign kd20  = 20'(deriv_gain_r);
  assign ks20  = kp20 + kd20;
  assign den_m = kd20 + (kp20 << 3) + (kp20 << 1);

  always_comb begin
    unique case (cidx_r)
      2'd0:    ncoef = (DV_W'(kd20) << 16) + DV_W'(den_m);
      2'd1:    ncoef = ((DV_W'(ks20) << 3) + (DV_W'(ks20) << 1) << 16) + DV_W'(den_m);
      default: ncoef = ((DV_W'(kd20) << 3) + (DV_W'(kd20) << 1) << 16) + DV_W'(den_m);
    endcase
  end

  assign nneg = (state_r == S_NT_GO || state_r == S_NT_WT) ? tc_r[SW-1] : meas_r[SW-1];
  always_comb begin
    if (state_r == S_NT_GO) begin
      nmag = tc_r[SW-1] ? SW'(-tc_r) : SW'(tc_r);
    end else begin
      nmag = meas_r[SW-1] ? SW'(-meas_r) : SW'(meas_r);
    end
  end

  assign abs_err = err_r[15] ? 16'(-err_r) : 16'(err_r);
  assign abse    = {abs_err, 3'b000};

  always_comb begin
    div_start = 1'b0;
    div_num   = DV_W'({nmag, 12'h000});
    div_den   = nneg ? DD_W'(negdiv) : DD_W'(smax);
    unique case (state_r)
      S_NT_GO, S_NM_GO: begin
        div_start = 1'b1;
      end
      S_W_GO: begin
        div_start = 1'b1;
        div_num   = DV_W'({16'(sep_upper_r - abse[15:0]), 15'h0000});
        div_den   = DD_W'(sep_upper_r - sep_lower_r);
      end
      S_C_GO: begin
        div_start = 1'b1;
        div_num   = ncoef;
        div_den   = DD_W'({den_m, 1'b0});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  psc_div #(.NUM_W(DV_W), .DEN_W(DD_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic signed [15:0] norm_q;
  always_comb begin
    if (!nneg) begin
      norm_q = (div_quo > DV_W'(32767)) ? 16'sh7fff : div_quo[15:0];
    end else begin
      norm_q = (div_quo > DV_W'(32768)) ? 16'sh8000 : 16'(-div_quo[15:0]);
    end
  end

  // multiplier
  psc_pkg::mac_cmd_t       mcmd;
  logic signed [A_W-1:0]   ma;
  logic signed [B_W-1:0]   mb;
  logic signed [ACC_W-1:0] acc;
  logic [IW-1:0]           imag;
  logic [MAGX_W-1:0]       imagx;

  assign imag  = integ_r[IW-1] ? IW'(-integ_r) : IW'(integ_r);
  assign imagx = MAGX_W'(imag);

  always_comb begin
    mcmd = '0;
    ma   = '0;
    mb   = '0;
    unique case (state_r)
      S_P: begin
        mcmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
        ma = A_W'(prop_gain_r);
        mb = B_W'(err_r);
      end
      S_K: begin
        mcmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
        ma = A_W'(w_r);
        mb = B_W'(integ_gain_r);
      end
      S_I0: begin
        mcmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
        ma = A_W'(k_r);
        mb = B_W'(imagx[psc_pkg::CHUNK_W-1:0]);
      end
      S_I1: begin
        mcmd = '{en: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b1};
        ma = A_W'(k_r);
        mb = B_W'(imagx[MAGX_W-1:psc_pkg::CHUNK_W]);
      end
      S_D0: begin
        mcmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
        ma = A_W'(deriv_gain_r);
        mb = B_W'(17'(err_r) - 17'(last_err_r));
      end
      S_F0: begin
        mcmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
        ma = A_W'(psc_pkg::LPF_NEW);
        mb = B_W'(x_r);
      end
      S_F1: begin
        mcmd = '{en: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b0};
        ma = A_W'(psc_pkg::LPF_OLD);
        mb = B_W'(fl_r);
      end
      S_M0: begin
        mcmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
        ma = A_W'(c1_r);
        mb = B_W'(dl_r);
      end
      S_M1: begin
        mcmd = '{en: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b0};
        ma = A_W'(c2_r);
        mb = B_W'(realn_r);
      end
      S_M2: begin
        mcmd = '{en: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b0};
        ma = A_W'(c3_r);
        mb = B_W'(ml_r);
      end
      S_OM: begin
        mcmd = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
        ma = sc_r[13] ? A_W'(negdiv) : A_W'(smax);
        mb = B_W'(sc_r);
      end
      default: begin
        mcmd = '0;
      end
    endcase
  end

  psc_mac #(.ACC_W(ACC_W)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mcmd),
    .a     (ma),
    .b     (mb),
    .acc   (acc)
  );

  // datapath helpers
  logic signed [16:0]    ediff;
  logic signed [15:0]    err_c;
  logic signed [WW-1:0]  m10, s7, n7;
  logic                  add_ok;
  logic [IW:0]           isum;
  logic signed [IW-1:0]  isum_c;
  logic signed [ACC_W-1:0] rnd15, rnd30, rnd12, drv_c;
  logic [IW:0]           ir;
  logic signed [SSW-1:0] ssum;
  logic out_load;

  assign ediff = 17'(setn_r) - 17'(realn_r);
  assign err_c = (ediff > 17'sd32767) ? 16'sh7fff :
                 (ediff < -17'sd32768) ? 16'sh8000 : ediff[15:0];

  assign meas_x = WW'(meas_r);
  assign m10    = (meas_x <<< 3) + (meas_x <<< 1);
  assign s7     = (smax_x <<< 3) - smax_x;
  assign n7     = -((negd_x <<< 3) - negd_x);
  always_comb begin
    if (m10 > s7) begin
      add_ok = err_c[15];
    end else if (m10 < n7) begin
      add_ok = !err_c[15] && (err_c != 16'sd0);
    end else begin
      add_ok = 1'b1;
    end
  end

  assign isum = {integ_r[IW-1], integ_r} + (IW+1)'(err_c);
  always_comb begin
    isum_c = isum[IW-1:0];
    if (isum[IW] != isum[IW-1]) begin
      isum_c = isum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end
  end

  assign rnd15 = rnd_sh(acc, 15);
  assign rnd30 = rnd_sh(acc, 30);
  assign rnd12 = rnd_sh(acc, 12);
  assign ir    = rnd30[IW:0];
  assign ssum  = SSW'(p_r) + SSW'(iterm_r) + SSW'(d_r);
  assign drv_c = (rnd12 > DLIM) ? DLIM : ((rnd12 < -DLIM) ? -DLIM : rnd12);
  assign out_load = (state_r == S_OR) && (!out_valid_r || out_ch.ready);

  // abse <= upper is evaluated at S_ERR from err_c, so rebuild it there
  logic [15:0] abs_c;
  logic [18:0] abse_c;
  assign abs_c  = err_c[15] ? 16'(-err_c) : 16'(err_c);
  assign abse_c = {abs_c, 3'b000};

  always_comb begin
    state_nxt = state_r;
    cidx_nxt  = cidx_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_NT_GO;
      S_NT_GO: state_nxt = S_NT_WT;
      S_NT_WT: if (div_done) state_nxt = S_NM_GO;
      S_NM_GO: state_nxt = S_NM_WT;
      S_NM_WT: if (div_done) state_nxt = S_ERR;
      S_ERR: begin
        if (abse_c > 19'(sep_upper_r) || abse_c < 19'(sep_lower_r) ||
            sep_upper_r == sep_lower_r) begin
          state_nxt = S_P;
        end else begin
          state_nxt = S_W_GO;
        end
      end
      S_W_GO:  state_nxt = S_W_WT;
      S_W_WT:  if (div_done) state_nxt = S_P;
      S_P:     state_nxt = S_K;
      S_K:     state_nxt = S_PR;
      S_PR:    state_nxt = S_KR;
      S_KR:    state_nxt = S_I0;
      S_I0:    state_nxt = S_I1;
      S_I1:    state_nxt = S_IW;
      S_IW:    state_nxt = S_IR;
      S_IR: begin
        cidx_nxt = 2'd0;
        if (deriv_mode_r == psc_pkg::DMODE_MEAS) begin
          state_nxt = (den_m == 20'd0) ? S_M0 : S_C_GO;
        end else begin
          state_nxt = S_D0;
        end
      end
      S_D0:    state_nxt = S_DW;
      S_DW:    state_nxt = S_DR;
      S_DR:    state_nxt = (deriv_mode_r == psc_pkg::DMODE_LPF) ? S_F0 : S_SUM;
      S_F0:    state_nxt = S_F1;
      S_F1:    state_nxt = S_FW;
      S_FW:    state_nxt = S_FR;
      S_FR:    state_nxt = S_SUM;
      S_C_GO:  state_nxt = S_C_WT;
      S_C_WT: begin
        if (div_done) begin
          cidx_nxt  = cidx_r + 2'd1;
          state_nxt = (cidx_r == 2'd2) ? S_M0 : S_C_GO;
        end
      end
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_MW;
      S_MW:    state_nxt = S_MR;
      S_MR:    state_nxt = S_SUM;
      S_SUM:   state_nxt = S_OM;
      S_OM:    state_nxt = S_OW;
      S_OW:    state_nxt = S_OR;
      S_OR:    if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cidx_r       <= 2'd0;
      out_valid_r  <= 1'b0;
      max_speed_r  <= 15'd300;
      min_speed_r  <= -16'sd300;
      prop_gain_r  <= 16'd22938;
      integ_gain_r <= 16'd6554;
      deriv_gain_r <= 16'd1638;
      sep_upper_r  <= 16'd16384;
      sep_lower_r  <= 16'd6554;
      deriv_mode_r <= psc_pkg::DMODE_PLAIN;
      integ_r      <= '0;
      last_err_r   <= '0;
      fl_r         <= '0;
      dl_r         <= '0;
      ml_r         <= '0;
    end else begin
      state_r <= state_nxt;
      cidx_r  <= cidx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          psc_pkg::REG_MAX_SPEED:  max_speed_r  <= cfg_ch.data[14:0];
          psc_pkg::REG_MIN_SPEED:  min_speed_r  <= cfg_ch.data;
          psc_pkg::REG_PROP_GAIN:  prop_gain_r  <= cfg_ch.data;
          psc_pkg::REG_INTEG_GAIN: integ_gain_r <= cfg_ch.data;
          psc_pkg::REG_DERIV_GAIN: deriv_gain_r <= cfg_ch.data;
          psc_pkg::REG_SEP_UPPER:  sep_upper_r  <= cfg_ch.data;
          psc_pkg::REG_SEP_LOWER:  sep_lower_r  <= cfg_ch.data;
          psc_pkg::REG_DERIV_MODE: deriv_mode_r <= cfg_ch.data[1:0];
          default: ;
        endcase
      end
      if (state_r == S_ERR && abse_c <= 19'(sep_upper_r) && add_ok) begin
        integ_r <= isum_c;
      end
      if (state_r == S_FR) begin
        fl_r <= sat16(rnd15);
      end
      if (state_r == S_MR) begin
        dl_r <= sat16(rnd15);
        ml_r <= realn_r;
      end
      if (out_load) begin
        last_err_r <= err_r;
      end
    end

    if (state_r == S_IDLE && in_ch.valid) begin
      tc_r   <= tcl_x[SW-1:0];
      meas_r <= in_ch.measured_speed;
    end
    if (state_r == S_NT_WT && div_done) setn_r <= norm_q;
    if (state_r == S_NM_WT && div_done) realn_r <= norm_q;
    if (state_r == S_ERR) begin
      err_r <= err_c;
      if (abse_c <= 19'(sep_upper_r) && abse_c < 19'(sep_lower_r)) begin
        w_r <= 17'd32768;
      end else if (abse_c > 19'(sep_upper_r) || sep_upper_r == sep_lower_r) begin
        w_r <= 17'd0;
      end else begin
        w_r <= 17'd32768;
      end
    end
    if (state_r == S_W_WT && div_done) begin
      w_r <= (div_quo > DV_W'(32768)) ? 17'd32768 : div_quo[16:0];
    end
    if (state_r == S_PR) p_r <= rnd15[19:0];
    if (state_r == S_KR) k_r <= acc[30:0];
    if (state_r == S_IR) begin
      iterm_r <= integ_r[IW-1] ? -$signed({1'b0, ir}) : $signed({1'b0, ir});
      if (den_m == 20'd0) begin
        c1_r <= 20'd0;
        c2_r <= 20'd32768;
        c3_r <= 20'd0;
      end
    end
    if (state_r == S_DR) begin
      x_r <= sat16(rnd15);
      d_r <= rnd15[19:0];
    end
    if (state_r == S_FR || state_r == S_MR) d_r <= 20'(sat16(rnd15));
    if (state_r == S_C_WT && div_done) begin
      unique case (cidx_r)
        2'd0:    c1_r <= div_quo[19:0];
        2'd1:    c2_r <= div_quo[19:0];
        default: c3_r <= div_quo[19:0];
      endcase
    end
    if (state_r == S_SUM) begin
      sat_r <= (ssum > S_ONE) || (ssum < -S_ONE);
      if (ssum > S_ONE) begin
        sc_r <= 14'sd4096;
      end else if (ssum < -S_ONE) begin
        sc_r <= -14'sd4096;
      end else begin
        sc_r <= ssum[13:0];
      end
    end
    if (out_load) begin
      out_drive_r <= drv_c[SW-1:0];
      out_sat_r   <= sat_r;
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive     = out_drive_r;
  assign out_ch.saturated = out_sat_r;
endmodule
`default_nettype wire

### bench/psc_checker.sv
// psc_checker: watches the sample, result and register channels of the PID speed
// controller, predicts each result and compares. Depends on psc_pkg and the channel interfaces.
module psc_checker (
  input  wire logic  clk,
  input  wire logic  rst_n,
  psc_in_if.sink     in_mon,
  psc_out_if.sink    out_mon,
  psc_cfg_if.sink    cfg_mon,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] drive;
    logic               saturated;
  } drive_res_t;

  drive_res_t drive_q[$];

  longint spd_max, spd_min, kp, ki, kd, thr_hi, thr_lo;
  logic [1:0] dmode;
  longint isum, err_prev, lpf_prev, dmeas_prev, meas_prev;

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint clamp16(longint x);
    return clamp(x, -32768, 32767);
  endfunction

  function automatic longint round_shift(longint x, int n);
    longint mag;
    mag = x < 0 ? -x : x;
    mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
    return x < 0 ? -mag : mag;
  endfunction

  function automatic longint to_q12(longint v, longint pdiv, longint ndiv);
    if (v >= 0) return clamp16((v * 4096) / pdiv);
    return clamp16(-(((-v) * 4096) / ndiv));
  endfunction

  task automatic predict_drive(longint tgt_in, longint meas);
    longint smax, smin, ndiv, tgt, setn, realn, err, abse, w, p, it, d, s, drv, x;
    longint c1, c2, c3, den;
    logic [63:0] k, mag, hi, lo, r;
    logic add, satf;
    drive_res_t res;
    smax = spd_max < 1 ? 1 : spd_max;
    smin = spd_min > -1 ? -1 : spd_min;
    ndiv = -smin;
    satf = 1'b0;
    tgt = clamp(tgt_in, smin, smax);
    setn = to_q12(tgt, smax, ndiv);
    realn = to_q12(meas, smax, ndiv);
    err = clamp16(setn - realn);
    abse = (err < 0 ? -err : err) * 8;
    if (abse > thr_hi) begin
      w = 0;
    end else begin
      if (abse < thr_lo) w = 32768;
      else if (thr_hi == thr_lo) w = 0;
      else w = clamp(((thr_hi - abse) * 32768) / (thr_hi - thr_lo), 0, 32768);
      if (meas * 10 > smax * 7) add = err < 0;
      else if (meas * 10 < smin * 7) add = err > 0;
      else add = 1'b1;
      if (add) isum = clamp(isum + err, -64'sd2147483648, 64'sd2147483647);
    end
    p = round_shift(kp * err, 15);
    k = w * ki;
    mag = isum < 0 ? -isum : isum;
    hi = mag >> 30;
    lo = mag & ((64'd1 << 30) - 1);
    r = k * hi + ((k * lo + (64'd1 << 29)) >> 30);
    it = isum < 0 ? -longint'(r) : longint'(r);
    if (dmode == psc_pkg::DMODE_LPF) begin
      x = clamp16(round_shift(kd * (err - err_prev), 15));
      d = clamp16(round_shift(psc_pkg::LPF_NEW * x + psc_pkg::LPF_OLD * lpf_prev, 15));
      lpf_prev = d;
    end else if (dmode == psc_pkg::DMODE_MEAS) begin
      den = kd + 10 * kp;
      if (den == 0) begin
        c1 = 0; c2 = 32768; c3 = 0;
      end else begin
        c1 = (kd * 65536 + den) / (2 * den);
        c2 = (10 * (kd + kp) * 65536 + den) / (2 * den);
        c3 = (10 * kd * 65536 + den) / (2 * den);
      end
      d = clamp16(round_shift(c1 * dmeas_prev + c2 * realn - c3 * meas_prev, 15));
      dmeas_prev = d;
      meas_prev = realn;
    end else begin
      d = round_shift(kd * (err - err_prev), 15);
    end
    err_prev = err;
    s = p + it + d;
    if (s > 4096) begin s = 4096; satf = 1'b1; end
    if (s < -4096) begin s = -4096; satf = 1'b1; end
    drv = s >= 0 ? round_shift(s * smax, 12) : round_shift(s * ndiv, 12);
    drv = clamp(drv, -32767, 32767);
    res.drive = drv[15:0];
    res.saturated = satf;
    drive_q.push_back(res);
  endtask

  always @(posedge clk) begin
    drive_res_t exp_res;
    if (!rst_n) begin
      spd_max = 300; spd_min = -300; kp = 22938; ki = 6554; kd = 1638;
      thr_hi = 16384; thr_lo = 6554; dmode = psc_pkg::DMODE_PLAIN;
      isum = 0; err_prev = 0; lpf_prev = 0; dmeas_prev = 0; meas_prev = 0;
      drive_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          psc_pkg::REG_MAX_SPEED:  spd_max = cfg_mon.data[14:0];
          psc_pkg::REG_MIN_SPEED:  spd_min = longint'($signed(cfg_mon.data));
          psc_pkg::REG_PROP_GAIN:  kp = cfg_mon.data;
          psc_pkg::REG_INTEG_GAIN: ki = cfg_mon.data;
          psc_pkg::REG_DERIV_GAIN: kd = cfg_mon.data;
          psc_pkg::REG_SEP_UPPER:  thr_hi = cfg_mon.data;
          psc_pkg::REG_SEP_LOWER:  thr_lo = cfg_mon.data;
          psc_pkg::REG_DERIV_MODE: dmode = cfg_mon.data[1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (drive_q.size() == 0) begin
          $error("unexpected result beat drive=%0d", out_mon.drive);
          fail_count = fail_count + 1;
        end else begin
          exp_res = drive_q.pop_front();
          if (out_mon.drive !== exp_res.drive) begin
            $error("drive: expected %0d actual %0d", exp_res.drive, out_mon.drive);
            fail_count = fail_count + 1;
          end
          if (out_mon.saturated !== exp_res.saturated) begin
            $error("saturated: expected %0b actual %0b", exp_res.saturated,
                   out_mon.saturated);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_drive(longint'(in_mon.target_speed), longint'(in_mon.measured_speed));
    end
    pending = drive_q.size();
  end
endmodule

### bench/pid_speed_controller_antiwindup_tb.sv
// pid_speed_controller_antiwindup_tb: drives samples and register writes with random
// gaps and stalls. Depends on psc_pkg, the channel interfaces, psc_checker and the block.
module pid_speed_controller_antiwindup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  int   stall_mode = 0;

  psc_in_if  in_ch();
  psc_out_if out_ch();
  psc_cfg_if cfg_ch();

  pid_speed_controller_antiwindup u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  psc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stall pattern; mode changes per phase
  always @(posedge clk) begin
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(3) != 0);
      default: out_ch.ready <= ($urandom_range(5) == 0);
    endcase
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sample(logic [15:0] tgt, logic [15:0] meas);
    in_ch.valid <= 1'b1;
    in_ch.target_speed <= tgt;
    in_ch.measured_speed <= meas;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_sender(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic load_regs(int unsigned mx, int mn, int unsigned p, int unsigned i,
                           int unsigned d, int unsigned hi, int unsigned lo, logic [1:0] m);
    write_reg(psc_pkg::REG_MAX_SPEED, mx[15:0]);
    write_reg(psc_pkg::REG_MIN_SPEED, mn[15:0]);
    write_reg(psc_pkg::REG_PROP_GAIN, p[15:0]);
    write_reg(psc_pkg::REG_INTEG_GAIN, i[15:0]);
    write_reg(psc_pkg::REG_DERIV_GAIN, d[15:0]);
    write_reg(psc_pkg::REG_SEP_UPPER, hi[15:0]);
    write_reg(psc_pkg::REG_SEP_LOWER, lo[15:0]);
    write_reg(psc_pkg::REG_DERIV_MODE, 16'(m));
  endtask

  task automatic random_phase(int n, int unsigned lim);
    int burst;
    int sent;
    logic [15:0] t, ms;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(8, 1);
      repeat (burst) begin
        if ($urandom_range(9) == 0) begin
          t = $urandom; ms = $urandom;
        end else begin
          t = 16'($signed($urandom_range(2 * lim + 40)) - int'(lim) - 20);
          ms = 16'($signed($urandom_range(2 * lim + 40)) - int'(lim) - 20);
        end
        send_sample(t, ms);
        sent++;
      end
      if ($urandom_range(3) != 0) pause_sender($urandom_range(400));
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.target_speed = '0; in_ch.measured_speed = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, both limits, zero error, all modes
    stall_mode = 0;
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd300, 16'sd250);
    send_sample(-16'sd300, -16'sd250);
    send_sample(16'sd100, 16'sd90);
    send_sample(16'sd100, 16'sd100);
    drain();
    load_regs(0, 0, 0, 0, 0, 100, 100, psc_pkg::DMODE_MEAS);
    send_sample(16'sd5, -16'sd5);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh7fff, 16'sh8000);
    drain();
    load_regs(32767, -32767, 32768, 32768, 32768, 32768, 0, psc_pkg::DMODE_LPF);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sd1000, 16'sd30000);
    send_sample(-16'sd1000, -16'sd30000);
    drain();
    load_regs(1000, -500, 20000, 10000, 3000, 8000, 8000, 2'd3);
    send_sample(16'sd1000, 16'sd0);
    send_sample(16'sd125, 16'sd0);
    send_sample(16'sd0, 16'sd0);
    drain();

    // random phases over several settings
    stall_mode = 1;
    load_regs(300, -300, 22938, 6554, 1638, 16384, 6554, psc_pkg::DMODE_PLAIN);
    random_phase(150, 300);
    stall_mode = 2;
    load_regs(2000, -800, 30000, 20000, 8000, 20000, 4000, psc_pkg::DMODE_LPF);
    random_phase(150, 2000);
    stall_mode = 0;
    load_regs(32767, -32767, 32768, 32768, 32768, 32768, 0, psc_pkg::DMODE_MEAS);
    random_phase(150, 32767);
    stall_mode = 1;
    load_regs(500, -1500, 10000, 30000, 0, 12000, 2000, psc_pkg::DMODE_MEAS);
    random_phase(150, 1500);
    stall_mode = 2;
    load_regs($urandom_range(32767, 1), -$urandom_range(32767, 1), $urandom_range(32768),
              $urandom_range(32768), $urandom_range(32768), $urandom_range(32768),
              $urandom_range(32768), 2'($urandom_range(3)));
    random_phase(150, 32767);
    stall_mode = 1;
    load_regs(1, -1, 32768, 32768, 32768, 0, 32768, psc_pkg::DMODE_PLAIN);
    random_phase(180, 20);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

### files.f
sv/psc_pkg.sv
sv/psc_in_if.sv
sv/psc_out_if.sv
sv/psc_cfg_if.sv
sv/psc_div.sv
sv/psc_mac.sv
sv/pid_speed_controller_antiwindup.sv
bench/psc_checker.sv
bench/pid_speed_controller_antiwindup_tb.sv
